// ===== design/ffla_pkg.sv =====
package ffla_pkg;

    localparam int NUM_FRAMES = 4096;
    localparam int FRAME_W    = 12;
    localparam int HI_W       = FRAME_W + 1;
    localparam int COUNT_W    = 10;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAME  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FIRST  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_LINK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] first_usable;
        logic [HI_W-1:0]    table_first;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] addr;
        logic [FRAME_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        link_wr_t           nxt;
        link_wr_t           prv;
        logic               used_we;
        logic [FRAME_W-1:0] used_addr;
        logic               used_data;
    } mem_wr_t;

    typedef struct packed {
        logic [FRAME_W-1:0] link_addr;
        logic [FRAME_W-1:0] used_addr;
    } mem_rd_t;

endpackage

// ===== design/ffla_ram.sv =====
module ffla_ram
    import ffla_pkg::*;
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/ffla_ctrl.sv =====
module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [COUNT_W-1:0]    s_page_count,
    input  logic [FRAME_W-1:0]    s_frame_index,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [FRAME_W-1:0]    m_granted_frame,
    output logic [STATUS_W-1:0]   m_status,
    output mem_rd_t               mem_rd,
    output mem_wr_t               mem_wr,
    input  logic [FRAME_W-1:0]    next_rd_data,
    input  logic [FRAME_W-1:0]    prev_rd_data,
    input  logic                  used_rd_data
);

    state_t state_reg, state_next;

    logic               clr_reg, clr_next;
    logic [FRAME_W-1:0] walk_reg, walk_next;
    logic [FRAME_W-1:0] head_reg, head_next;
    logic               empty_reg, empty_next;
    logic               m_valid_reg, m_valid_next;

    logic [FRAME_W-1:0]  idx_reg, idx_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FRAME_W-1:0]  m_frame_reg, m_frame_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic               out_free;
    logic               walk_last;
    logic [HI_W-1:0]    walk_ext, lo_ext, hi_ext, succ_ext, hi_m1;
    logic               range_ok, in_range;
    logic [FRAME_W-1:0] walk_nxt_val, walk_prv_val;
    logic               alloc_reject, free_reject;

    assign out_free  = !m_valid_reg || m_tready;
    assign walk_last = (walk_reg == FRAME_W'(NUM_FRAMES - 1));

    // init range bounds
    assign walk_ext = {1'b0, walk_reg};
    assign lo_ext   = {1'b0, cfg.first_usable};
    assign hi_ext   = (cfg.table_first > HI_W'(NUM_FRAMES)) ? HI_W'(NUM_FRAMES)
                                                            : cfg.table_first;
    assign succ_ext = walk_ext + HI_W'(1);
    assign hi_m1    = hi_ext - HI_W'(1);
    assign range_ok = (lo_ext < hi_ext);
    assign in_range = !clr_reg && (walk_ext >= lo_ext) && (walk_ext < hi_ext);
    assign walk_nxt_val = (succ_ext < hi_ext) ? succ_ext[FRAME_W-1:0] : cfg.first_usable;
    assign walk_prv_val = (walk_ext > lo_ext) ? (walk_reg - FRAME_W'(1))
                                              : hi_m1[FRAME_W-1:0];

    assign alloc_reject = (s_page_count != COUNT_W'(1)) || empty_reg;
    assign free_reject  = (s_frame_index < cfg.first_usable);

    assign mem_rd.link_addr = head_reg;
    assign mem_rd.used_addr = idx_reg;

    assign m_tvalid        = m_valid_reg;
    assign m_granted_frame = m_frame_reg;
    assign m_status        = m_status_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_func)
                        FUNC_ALLOC: state_next = alloc_reject ? S_RESP : S_ALLOC_RD;
                        FUNC_FREE:  state_next = free_reject ? S_RESP : S_FREE_RD;
                        FUNC_INIT:  state_next = S_WALK;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    state_next = clr_reg ? S_IDLE : S_RESP;
                end
            end
            S_ALLOC_RD: state_next = S_ALLOC_WR;
            S_ALLOC_WR: state_next = S_RESP;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK: begin
                if (!used_rd_data || empty_reg) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_FREE_LINK;
                end
            end
            S_FREE_LINK: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready        = (state_reg == S_IDLE);
        mem_wr          = '0;
        clr_next        = clr_reg;
        walk_next       = walk_reg;
        head_next       = head_reg;
        empty_next      = empty_reg;
        idx_next        = idx_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_frame_next    = m_frame_reg;
        m_status_next   = m_status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    idx_next        = s_frame_index;
                    res_frame_next  = '0;
                    res_status_next = STATUS_OK;
                    walk_next       = '0;
                    clr_next        = 1'b0;
                    case (s_func)
                        FUNC_ALLOC: begin
                            if (s_page_count != COUNT_W'(1)) begin
                                res_status_next = STATUS_BAD_COUNT;
                            end else if (empty_reg) begin
                                res_status_next = STATUS_NO_FRAME;
                            end
                        end
                        FUNC_FREE: begin
                            if (free_reject) begin
                                res_status_next = STATUS_IGNORED;
                            end
                        end
                        FUNC_INIT: res_status_next = STATUS_OK;
                        default:   res_status_next = STATUS_IGNORED;
                    endcase
                end
            end
            S_WALK: begin
                mem_wr.used_we   = 1'b1;
                mem_wr.used_addr = walk_reg;
                mem_wr.used_data = !in_range;
                mem_wr.nxt.we    = in_range;
                mem_wr.nxt.addr  = walk_reg;
                mem_wr.nxt.data  = walk_nxt_val;
                mem_wr.prv.we    = in_range;
                mem_wr.prv.addr  = walk_reg;
                mem_wr.prv.data  = walk_prv_val;
                walk_next        = walk_reg + FRAME_W'(1);
                if (walk_last) begin
                    if (range_ok && !clr_reg) begin
                        head_next  = cfg.first_usable;
                        empty_next = 1'b0;
                    end else begin
                        head_next  = '0;
                        empty_next = 1'b1;
                    end
                    clr_next = 1'b0;
                end
            end
            S_ALLOC_WR: begin
                // unlink head: prev[n] = p, next[p] = n
                mem_wr.prv.we    = 1'b1;
                mem_wr.prv.addr  = next_rd_data;
                mem_wr.prv.data  = prev_rd_data;
                mem_wr.nxt.we    = 1'b1;
                mem_wr.nxt.addr  = prev_rd_data;
                mem_wr.nxt.data  = next_rd_data;
                mem_wr.used_we   = 1'b1;
                mem_wr.used_addr = head_reg;
                mem_wr.used_data = 1'b1;
                if (next_rd_data == head_reg) begin
                    empty_next = 1'b1;
                end else begin
                    head_next = next_rd_data;
                end
                res_frame_next  = head_reg;
                res_status_next = STATUS_OK;
            end
            S_FREE_CHK: begin
                if (!used_rd_data) begin
                    res_status_next = STATUS_IGNORED;
                end else if (empty_reg) begin
                    mem_wr.prv.we    = 1'b1;
                    mem_wr.prv.addr  = idx_reg;
                    mem_wr.prv.data  = idx_reg;
                    mem_wr.nxt.we    = 1'b1;
                    mem_wr.nxt.addr  = idx_reg;
                    mem_wr.nxt.data  = idx_reg;
                    mem_wr.used_we   = 1'b1;
                    mem_wr.used_addr = idx_reg;
                    mem_wr.used_data = 1'b0;
                    head_next        = idx_reg;
                    empty_next       = 1'b0;
                end else begin
                    // first half of insert before head: prev[idx] = p, next[p] = idx
                    mem_wr.prv.we    = 1'b1;
                    mem_wr.prv.addr  = idx_reg;
                    mem_wr.prv.data  = prev_rd_data;
                    mem_wr.nxt.we    = 1'b1;
                    mem_wr.nxt.addr  = prev_rd_data;
                    mem_wr.nxt.data  = idx_reg;
                    mem_wr.used_we   = 1'b1;
                    mem_wr.used_addr = idx_reg;
                    mem_wr.used_data = 1'b0;
                end
            end
            S_FREE_LINK: begin
                mem_wr.prv.we   = 1'b1;
                mem_wr.prv.addr = head_reg;
                mem_wr.prv.data = idx_reg;
                mem_wr.nxt.we   = 1'b1;
                mem_wr.nxt.addr = idx_reg;
                mem_wr.nxt.data = head_reg;
                head_next       = idx_reg;
                empty_next      = 1'b0;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = res_frame_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_WALK;
            clr_reg     <= 1'b1;
            walk_reg    <= '0;
            head_reg    <= '0;
            empty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            walk_reg    <= walk_next;
            head_reg    <= head_next;
            empty_reg   <= empty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        m_frame_reg    <= m_frame_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// ===== design/frame_free_list_allocator.sv =====
// channel  | direction | tdata (lsb first)                       | tuser
// ---------+-----------+-----------------------------------------+--------------
// s_       | in        | page_count[9:0], frame_index[21:10], pad | func[1:0]
// m_       | out       | granted_frame[11:0], pad                 | status[1:0]
// cfg_     | in        | cfg_index selects register, cfg_data     | -
//
// one request at a time; allocate unlinks the head; free may link the frame in
// before the head; a request rejected up front skips the memories; initialize
// walks one frame per cycle through the link and used memories (one write port
// each); after reset a pass marks every frame used; s_tready stays low meanwhile
// a finished result waits in the output register while the next transaction is taken
module frame_free_list_allocator
    import ffla_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // page_count[9:0], frame_index[21:10]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // granted_frame[11:0]
    output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    mem_rd_t mem_rd;
    mem_wr_t mem_wr;

    logic [FRAME_W-1:0]  next_rd_data;
    logic [FRAME_W-1:0]  prev_rd_data;
    logic                used_rd_data;
    logic [FRAME_W-1:0]  granted_frame;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FIRST_USABLE: cfg_next.first_usable = cfg_data[FRAME_W-1:0];
                CFG_TABLE_FIRST:  cfg_next.table_first  = cfg_data[HI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_usable <= FRAME_W'(1);
            cfg_reg.table_first  <= HI_W'(NUM_FRAMES);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: decodes requests, walks the list memories, holds the result
    ffla_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_func          (s_tuser),
        .s_page_count    (s_tdata[COUNT_W-1:0]),
        .s_frame_index   (s_tdata[COUNT_W+FRAME_W-1:COUNT_W]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_granted_frame (granted_frame),
        .m_status        (m_tuser),
        .mem_rd          (mem_rd),
        .mem_wr          (mem_wr),
        .next_rd_data    (next_rd_data),
        .prev_rd_data    (prev_rd_data),
        .used_rd_data    (used_rd_data)
    );

    assign m_tdata = {4'b0, granted_frame};

    // successor links, read at the head
    ffla_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_next_ram (
        .aclk    (aclk),
        .we      (mem_wr.nxt.we),
        .wr_addr (mem_wr.nxt.addr),
        .wr_data (mem_wr.nxt.data),
        .rd_addr (mem_rd.link_addr),
        .rd_data (next_rd_data)
    );

    // predecessor links, read at the head
    ffla_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_prev_ram (
        .aclk    (aclk),
        .we      (mem_wr.prv.we),
        .wr_addr (mem_wr.prv.addr),
        .wr_data (mem_wr.prv.data),
        .rd_addr (mem_rd.link_addr),
        .rd_data (prev_rd_data)
    );

    // used bit per frame, read at the frame being freed
    ffla_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_used_ram (
        .aclk    (aclk),
        .we      (mem_wr.used_we),
        .wr_addr (mem_wr.used_addr),
        .wr_data (mem_wr.used_data),
        .rd_addr (mem_rd.used_addr),
        .rd_data (used_rd_data)
    );

endmodule
